>>> rtl/core/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared types and constants of the RGB to HSV pixel converter.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned RECIP_W = 17;  // entry 1 holds 65536
  localparam int unsigned RECIP_N = 256;

  // Hue sector offsets in half degrees
  localparam logic [7:0] HUE_OFS_RED   = 8'd0;
  localparam logic [7:0] HUE_OFS_GREEN = 8'd60;
  localparam logic [7:0] HUE_OFS_BLUE  = 8'd120;
  localparam logic [7:0] HUE_WRAP      = 8'd180;

  localparam logic [7:0] SAT_SCALE = 8'd255;
  localparam logic [4:0] HUE_SCALE = 5'd30;

  typedef logic [CHAN_W-1:0] chan_t;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

endpackage

>>> rtl/core/rgbhsv_in_if.sv
// ----------------------------------------------------------------------------
// rgbhsv_in_if
// Valid/ready channel carrying one RGB pixel with user and last sideband.
// ----------------------------------------------------------------------------
interface rgbhsv_in_if;
  logic                 valid;
  logic                 ready;
  rgbhsv_pkg::chan_t    red;
  rgbhsv_pkg::chan_t    green;
  rgbhsv_pkg::chan_t    blue;
  logic                 user_flag;
  logic                 last_flag;

  modport source (output valid, red, green, blue, user_flag, last_flag, input ready);
  modport sink   (input valid, red, green, blue, user_flag, last_flag, output ready);
endinterface

>>> rtl/core/rgbhsv_out_if.sv
// ----------------------------------------------------------------------------
// rgbhsv_out_if
// Valid/ready channel carrying one HSV pixel with user and last sideband.
// ----------------------------------------------------------------------------
interface rgbhsv_out_if;
  logic                 valid;
  logic                 ready;
  rgbhsv_pkg::chan_t    hue;
  rgbhsv_pkg::chan_t    saturation;
  rgbhsv_pkg::chan_t    brightness;
  logic                 user_out;
  logic                 last_out;

  modport source (output valid, hue, saturation, brightness, user_out, last_out,
                  input ready);
  modport sink   (input valid, hue, saturation, brightness, user_out, last_out,
                  output ready);
endinterface

>>> rtl/core/rgb_to_hsv_pixel.sv
// A pixel moves through the stage 1 to 4 registers, which a low hsv.ready can stall.
// Throughput: one pixel per cycle unless stalled; four register stages, each with
// its own valid bit, and a stage takes new data whenever it is empty or its
// successor moves. The hue and saturation multipliers in stage 3 set the cycle
// time. Reset (rst, synchronous) clears the stage valid bits only; no pixel state.
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel
// Pipelined RGB to HSV converter: hue 0..179, saturation 0..255, value = max.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel (
  input  logic                clk,
  input  logic                rst,
  rgbhsv_in_if.sink           pixel,
  rgbhsv_out_if.source        hsv
);

  // Reciprocal table: entry i = (65536 + i/2) / i, entry 0 = 0
  logic [rgbhsv_pkg::RECIP_W-1:0] recip_tab [rgbhsv_pkg::RECIP_N];

  for (genvar gi = 0; gi < rgbhsv_pkg::RECIP_N; gi++) begin : g_recip
    if (gi == 0) begin : g_zero
      assign recip_tab[gi] = '0;
    end else begin : g_ent
      localparam int unsigned RVAL = (65536 + gi / 2) / gi;
      assign recip_tab[gi] = rgbhsv_pkg::RECIP_W'(RVAL);
    end
  end

  // Stage enables
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  assign en4 = !v4 || hsv.ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign pixel.ready = en1;

  // ---------------- Stage 1: max, min, sector, difference ----------------
  rgbhsv_pkg::chan_t   mx, mn, rg_max, rg_min;
  rgbhsv_pkg::sector_t sec;
  logic signed [8:0]   diff;
  rgbhsv_pkg::chan_t   abs_diff;

  always_comb begin
    rg_max = (pixel.red > pixel.green) ? pixel.red : pixel.green;
    rg_min = (pixel.red < pixel.green) ? pixel.red : pixel.green;
    mx     = (pixel.blue > rg_max) ? pixel.blue : rg_max;
    mn     = (pixel.blue < rg_min) ? pixel.blue : rg_min;
    if (mx == pixel.red) begin
      sec  = rgbhsv_pkg::SEC_RED;
      diff = $signed({1'b0, pixel.green}) - $signed({1'b0, pixel.blue});
    end else if (mx == pixel.green) begin
      sec  = rgbhsv_pkg::SEC_GREEN;
      diff = $signed({1'b0, pixel.blue}) - $signed({1'b0, pixel.red});
    end else begin
      sec  = rgbhsv_pkg::SEC_BLUE;
      diff = $signed({1'b0, pixel.red}) - $signed({1'b0, pixel.green});
    end
    abs_diff = diff[8] ? 8'(-diff) : diff[7:0];
  end

  rgbhsv_pkg::chan_t   s1_max, s1_delta, s1_abs;
  rgbhsv_pkg::sector_t s1_sec;
  logic                s1_neg, s1_user, s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= pixel.valid;
    end
    if (en1) begin
      s1_max   <= mx;
      s1_delta <= mx - mn;
      s1_abs   <= abs_diff;
      s1_sec   <= sec;
      s1_neg   <= diff[8];
      s1_user  <= pixel.user_flag;
      s1_last  <= pixel.last_flag;
    end
  end

  // ---------------- Stage 2: table lookups, constant scaling ----------------
  logic [rgbhsv_pkg::RECIP_W-1:0] s2_rmax, s2_rdelta;
  logic [15:0]                    s2_d255;
  logic [12:0]                    s2_d30;
  rgbhsv_pkg::chan_t              s2_max;
  rgbhsv_pkg::sector_t            s2_sec;
  logic                           s2_neg, s2_user, s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      s2_rmax   <= recip_tab[s1_max];
      s2_rdelta <= recip_tab[s1_delta];
      s2_d255   <= 16'(s1_delta * rgbhsv_pkg::SAT_SCALE);
      s2_d30    <= 13'(s1_abs * rgbhsv_pkg::HUE_SCALE);
      s2_max    <= s1_max;
      s2_sec    <= s1_sec;
      s2_neg    <= s1_neg;
      s2_user   <= s1_user;
      s2_last   <= s1_last;
    end
  end

  // ---------------- Stage 3: multiplies ----------------
  logic [32:0] sat_prod;
  logic [29:0] hue_prod;

  assign sat_prod = s2_d255 * s2_rmax;
  assign hue_prod = s2_d30 * s2_rdelta;

  rgbhsv_pkg::chan_t   s3_sat, s3_max;
  logic [29:0]         s3_mag;
  rgbhsv_pkg::sector_t s3_sec;
  logic                s3_neg, s3_user, s3_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
    if (en3) begin
      s3_sat  <= sat_prod[23:16];
      s3_mag  <= hue_prod;
      s3_max  <= s2_max;
      s3_sec  <= s2_sec;
      s3_neg  <= s2_neg;
      s3_user <= s2_user;
      s3_last <= s2_last;
    end
  end

  // ---------------- Stage 4: hue shift, offset, wrap ----------------
  logic [30:0]        mag_sum;
  logic [14:0]        q;
  logic [7:0]         ofs;
  logic signed [15:0] h_raw, h_fix;

  always_comb begin
    // floor of a negative quotient: round the magnitude up
    mag_sum = s3_neg ? ({1'b0, s3_mag} + 31'd65535) : {1'b0, s3_mag};
    q       = mag_sum[30:16];
    case (s3_sec)
      rgbhsv_pkg::SEC_RED:   ofs = rgbhsv_pkg::HUE_OFS_RED;
      rgbhsv_pkg::SEC_GREEN: ofs = rgbhsv_pkg::HUE_OFS_GREEN;
      rgbhsv_pkg::SEC_BLUE:  ofs = rgbhsv_pkg::HUE_OFS_BLUE;
      default:               ofs = rgbhsv_pkg::HUE_OFS_RED;
    endcase
    if (s3_neg) begin
      h_raw = $signed({8'd0, ofs}) - $signed({1'b0, q});
    end else begin
      h_raw = $signed({8'd0, ofs}) + $signed({1'b0, q});
    end
    h_fix = h_raw[15] ? (h_raw + $signed({8'd0, rgbhsv_pkg::HUE_WRAP})) : h_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
    if (en4) begin
      hsv.hue        <= h_fix[7:0];
      hsv.saturation <= s3_sat;
      hsv.brightness <= s3_max;
      hsv.user_out   <= s3_user;
      hsv.last_out   <= s3_last;
    end
  end

  assign hsv.valid = v4;

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rgb_to_hsv_pixel. Pixels go in over the input
// channel. Each transfer is predicted in place: value is the max channel,
// saturation and hue use the reciprocal formula of the table, and the sideband bits
// are copied. Results are matched in order against a queue of predictions.
// Both channels idle at random, with one burst that has no idling at all.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 1000;  // cycles without any transfer
  localparam int DRAIN_CYCLES = 12;    // pipeline is 4 deep
  localparam int SHOW_LIMIT   = 10;

  typedef struct packed {
    rgbhsv_pkg::chan_t hue;
    rgbhsv_pkg::chan_t saturation;
    rgbhsv_pkg::chan_t brightness;
    logic              user_out;
    logic              last_out;
  } hsv_t;

  logic clk = 1'b0;
  logic rst;

  rgbhsv_in_if  pixel_ch ();
  rgbhsv_out_if hsv_ch ();

  rgb_to_hsv_pixel i_dut (
    .clk   (clk),
    .rst   (rst),
    .pixel (pixel_ch),
    .hsv   (hsv_ch)
  );

  always #5 clk = ~clk;

  hsv_t pending_hsv[$];
  int   mismatch_count = 0;
  int   shown_count    = 0;
  int   stall_cycles   = 0;
  bit   idle_on        = 1'b1;

  // ---------------------------------------------------------------- predictor

  function automatic int recip_of(input int d);
    if (d == 0) return 0;
    return (65536 + d / 2) / d;
  endfunction

  function automatic hsv_t hsv_of(input rgbhsv_pkg::chan_t r,
                                  input rgbhsv_pkg::chan_t g,
                                  input rgbhsv_pkg::chan_t b,
                                  input logic u, input logic l);
    hsv_t                res;
    int                  hi, lo, span, diff, base;
    longint              sat_p, hue_p, h;
    rgbhsv_pkg::sector_t sec;
    hi   = (r > g) ? r : g;
    lo   = (r < g) ? r : g;
    if (b > hi) hi = b;
    if (b < lo) lo = b;
    span = hi - lo;

    res            = '0;
    res.brightness = rgbhsv_pkg::chan_t'(hi);
    res.user_out   = u;
    res.last_out   = l;

    if (hi != 0) begin
      sat_p          = longint'(span) * int'(rgbhsv_pkg::SAT_SCALE) * recip_of(hi);
      res.saturation = sat_p[23:16];
    end

    if (span != 0) begin
      // red is tested first, then green, so ties go to the earlier channel
      if (hi == r)      sec = rgbhsv_pkg::SEC_RED;
      else if (hi == g) sec = rgbhsv_pkg::SEC_GREEN;
      else              sec = rgbhsv_pkg::SEC_BLUE;
      case (sec)
        rgbhsv_pkg::SEC_RED: begin
          diff = int'(g) - int'(b);
          base = int'(rgbhsv_pkg::HUE_OFS_RED);
        end
        rgbhsv_pkg::SEC_GREEN: begin
          diff = int'(b) - int'(r);
          base = int'(rgbhsv_pkg::HUE_OFS_GREEN);
        end
        default: begin
          diff = int'(r) - int'(g);
          base = int'(rgbhsv_pkg::HUE_OFS_BLUE);
        end
      endcase
      hue_p = longint'(diff) * int'(rgbhsv_pkg::HUE_SCALE) * recip_of(span);
      h     = (hue_p >>> 16) + base;  // floor toward minus infinity
      if (h < 0) h = h + int'(rgbhsv_pkg::HUE_WRAP);
      res.hue = h[7:0];
    end
    return res;
  endfunction

  // ------------------------------------------------------------------ driving

  // Called at a rising edge; returns at the edge of the transfer.
  task automatic send_pixel(input rgbhsv_pkg::chan_t r, input rgbhsv_pkg::chan_t g,
                            input rgbhsv_pkg::chan_t b, input logic u, input logic l);
    while (idle_on && $urandom_range(0, 99) < 6) begin
      pixel_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pixel_ch.valid     <= 1'b1;
    pixel_ch.red       <= r;
    pixel_ch.green     <= g;
    pixel_ch.blue      <= b;
    pixel_ch.user_flag <= u;
    pixel_ch.last_flag <= l;
    // once valid is up the pixel is committed, so queue it now
    pending_hsv.push_back(hsv_of(r, g, b, u, l));
    do @(posedge clk); while (!(pixel_ch.valid && pixel_ch.ready));
  endtask

  always @(posedge clk) begin
    hsv_ch.ready <= !(idle_on && ($urandom_range(0, 99) < 6));
  end

  // ----------------------------------------------------------------- checking

  always @(posedge clk) begin
    hsv_t want;
    if (!rst && hsv_ch.valid && hsv_ch.ready) begin
      if (pending_hsv.size() == 0) begin
        mismatch_count++;
        if (shown_count < SHOW_LIMIT) begin
          shown_count++;
          $display("[%0t] unexpected result h=%0d s=%0d v=%0d u=%b l=%b", $realtime,
                   hsv_ch.hue, hsv_ch.saturation, hsv_ch.brightness,
                   hsv_ch.user_out, hsv_ch.last_out);
        end
      end else begin
        want = pending_hsv.pop_front();
        if (hsv_ch.hue !== want.hue || hsv_ch.saturation !== want.saturation ||
            hsv_ch.brightness !== want.brightness ||
            hsv_ch.user_out !== want.user_out || hsv_ch.last_out !== want.last_out) begin
          mismatch_count++;
          if (shown_count < SHOW_LIMIT) begin
            shown_count++;
            $display("[%0t] mismatch: expected h=%0d s=%0d v=%0d u=%b l=%b,",
                     $realtime, want.hue, want.saturation, want.brightness,
                     want.user_out, want.last_out,
                     " got h=%0d s=%0d v=%0d u=%b l=%b", hsv_ch.hue,
                     hsv_ch.saturation, hsv_ch.brightness, hsv_ch.user_out,
                     hsv_ch.last_out);
          end
        end
      end
    end
  end

  // watchdog: any transfer on either side resets the count
  always @(posedge clk) begin
    if ((pixel_ch.valid && pixel_ch.ready) || (hsv_ch.valid && hsv_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles = stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------- tests

  task automatic test_directed();
    send_pixel(8'd0,   8'd0,   8'd0,   1'b0, 1'b0);  // black
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b1);  // white
    send_pixel(8'd128, 8'd128, 8'd128, 1'b0, 1'b1);  // grey
    send_pixel(8'd1,   8'd0,   8'd0,   1'b1, 1'b0);  // dimmest color
    send_pixel(8'd255, 8'd0,   8'd0,   1'b0, 1'b0);
    send_pixel(8'd0,   8'd255, 8'd0,   1'b1, 1'b1);
    send_pixel(8'd0,   8'd0,   8'd255, 1'b0, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd0,   1'b1, 1'b0);  // red/green tie
    send_pixel(8'd0,   8'd255, 8'd255, 1'b0, 1'b0);  // green/blue tie
    send_pixel(8'd255, 8'd0,   8'd255, 1'b1, 1'b1);  // red/blue tie, wraps
    send_pixel(8'd255, 8'd0,   8'd1,   1'b0, 1'b1);  // red sector, wraps
    send_pixel(8'd255, 8'd1,   8'd0,   1'b1, 1'b0);
    send_pixel(8'd0,   8'd1,   8'd255, 1'b0, 1'b0);  // blue sector, negative diff
    send_pixel(8'd1,   8'd255, 8'd0,   1'b1, 1'b1);  // green sector, negative diff
    send_pixel(8'd2,   8'd1,   8'd1,   1'b0, 1'b1);  // smallest delta
    send_pixel(8'd255, 8'd254, 8'd254, 1'b1, 1'b0);
    send_pixel(8'd254, 8'd255, 8'd255, 1'b0, 1'b0);
    send_pixel(8'd170, 8'd85,  8'd0,   1'b1, 1'b1);
    send_pixel(8'd1,   8'd1,   8'd0,   1'b0, 1'b1);
    send_pixel(8'd0,   8'd128, 8'd127, 1'b1, 1'b0);
  endtask

  task automatic test_random_pixels(input int count);
    repeat (count) begin
      send_pixel(rgbhsv_pkg::chan_t'($urandom_range(0, 255)),
                 rgbhsv_pkg::chan_t'($urandom_range(0, 255)),
                 rgbhsv_pkg::chan_t'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  // channels within a few counts of each other: small deltas and frequent ties
  task automatic test_near_grey(input int count);
    int base;
    repeat (count) begin
      base = $urandom_range(0, 252);
      send_pixel(rgbhsv_pkg::chan_t'(base + $urandom_range(0, 3)),
                 rgbhsv_pkg::chan_t'(base + $urandom_range(0, 3)),
                 rgbhsv_pkg::chan_t'(base + $urandom_range(0, 3)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_back_to_back(input int count);
    idle_on = 1'b0;
    test_random_pixels(count);
    idle_on = 1'b1;
  endtask

  initial begin
    rst                <= 1'b1;
    pixel_ch.valid     <= 1'b0;
    pixel_ch.red       <= '0;
    pixel_ch.green     <= '0;
    pixel_ch.blue      <= '0;
    pixel_ch.user_flag <= 1'b0;
    pixel_ch.last_flag <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_back_to_back(60);
    test_random_pixels(260);
    test_near_grey(60);

    pixel_ch.valid <= 1'b0;
    while (pending_hsv.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> rgb_to_hsv_pixel.f
rtl/core/rgbhsv_pkg.sv
rtl/core/rgbhsv_in_if.sv
rtl/core/rgbhsv_out_if.sv
rtl/core/rgb_to_hsv_pixel.sv
tb/tb.sv
